@@ rtl/jse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg: shared definitions for the json string escaper
// item modes, escape kinds, queue descriptor and byte sequence helpers
// ----------------------------------------------------------------------------
package jse_pkg;

    // depth of the descriptor queue between front and back
    localparam int unsigned QueueDepth = 2;

    // input item modes (tuser)
    localparam logic [1:0] MODE_OPEN  = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    // characters used by the escapes
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // step counter through one escape sequence (up to six bytes)
    typedef logic [2:0] step_t;

    localparam step_t STEP_BSLASH = 3'd0;
    localparam step_t STEP_U      = 3'd1;
    localparam step_t STEP_ZERO_A = 3'd2;
    localparam step_t STEP_ZERO_B = 3'd3;
    localparam step_t STEP_HEX_HI = 3'd4;

    // how a classified item is written out
    typedef enum logic [1:0] {
        KIND_QUOTE,  // single double quote
        KIND_PLAIN,  // byte passes through
        KIND_PAIR,   // backslash then value
        KIND_UNI     // backslash u 0 0 hex hex of value
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } desc_t;

    function automatic step_t seq_len(input kind_t kind);
        step_t len;
        unique case (kind)
            KIND_QUOTE: len = 3'd1;
            KIND_PLAIN: len = 3'd1;
            KIND_PAIR:  len = 3'd2;
            KIND_UNI:   len = 3'd6;
            default:    len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/jse_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_front: input classifier
// takes input beats and turns each open, byte or close beat into an escape descriptor for the queue
// ----------------------------------------------------------------------------
module jse_front
(
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,
    input  logic              queue_full,
    output logic              push,
    output jse_pkg::desc_t    push_desc
);

    logic accept;

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        push            = 1'b0;
        push_desc.kind  = jse_pkg::KIND_PLAIN;
        push_desc.value = s_axis_tdata;
        unique case (s_axis_tuser)
            jse_pkg::MODE_OPEN, jse_pkg::MODE_CLOSE:
            begin
                push           = accept;
                push_desc.kind = jse_pkg::KIND_QUOTE;
            end
            jse_pkg::MODE_BYTE:
            begin
                push = accept;
                if (s_axis_tdata == jse_pkg::CH_QUOTE || s_axis_tdata == jse_pkg::CH_BSLASH)
                begin
                    push_desc.kind = jse_pkg::KIND_PAIR;
                end
                else if (s_axis_tdata == jse_pkg::CH_LF)
                begin
                    push_desc.kind  = jse_pkg::KIND_PAIR;
                    push_desc.value = jse_pkg::CH_N;
                end
                else if (s_axis_tdata == jse_pkg::CH_CR)
                begin
                    push_desc.kind  = jse_pkg::KIND_PAIR;
                    push_desc.value = jse_pkg::CH_R;
                end
                else if (s_axis_tdata == jse_pkg::CH_TAB)
                begin
                    push_desc.kind  = jse_pkg::KIND_PAIR;
                    push_desc.value = jse_pkg::CH_T;
                end
                else if (s_axis_tdata < jse_pkg::CTRL_LIMIT || s_axis_tdata == jse_pkg::CH_LT ||
                         s_axis_tdata == jse_pkg::CH_GT || s_axis_tdata == jse_pkg::CH_AMP)
                begin
                    push_desc.kind = jse_pkg::KIND_UNI;
                end
            end
            // reserved mode: beat is taken and dropped
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/jse_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue: descriptor queue
// short fifo of escape descriptors between classifier and byte sequencer
// ----------------------------------------------------------------------------
module jse_queue
#(
    parameter int unsigned Depth = jse_pkg::QueueDepth
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jse_pkg::desc_t    push_desc,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output jse_pkg::desc_t    head_desc
);

    localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntWidth = $clog2(Depth + 1);
    localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
    localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

    jse_pkg::desc_t      slot_reg [Depth];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign full       = (count_reg == CntFull);
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // overflow and underflow would lose or invent bytes
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
        else $error("queue pop while empty");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntFull)
        else $error("queue count out of range");

endmodule

@@ rtl/jse_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_back: byte sequencer
// walks the head descriptor one byte per beat into the output register
// ----------------------------------------------------------------------------
module jse_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  jse_pkg::desc_t    head_desc,
    output logic              pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast
);

    jse_pkg::step_t step_reg, step_next;
    jse_pkg::step_t len;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_data_reg;
    logic           out_last_reg;
    logic           load_en;
    logic           take;
    logic           is_last;
    logic [7:0]     cur_byte;

    assign load_en = !out_valid_reg || m_axis_tready;
    assign take    = load_en && head_valid;
    assign len     = jse_pkg::seq_len(head_desc.kind);
    assign is_last = (step_reg == len - 3'd1);
    assign pop     = take && is_last;

    always_comb
    begin
        unique case (head_desc.kind)
            jse_pkg::KIND_QUOTE: cur_byte = jse_pkg::CH_QUOTE;
            jse_pkg::KIND_PLAIN: cur_byte = head_desc.value;
            jse_pkg::KIND_PAIR:
                cur_byte = (step_reg == jse_pkg::STEP_BSLASH) ? jse_pkg::CH_BSLASH
                                                              : head_desc.value;
            jse_pkg::KIND_UNI:
            begin
                unique case (step_reg)
                    jse_pkg::STEP_BSLASH: cur_byte = jse_pkg::CH_BSLASH;
                    jse_pkg::STEP_U:      cur_byte = jse_pkg::CH_U;
                    jse_pkg::STEP_ZERO_A,
                    jse_pkg::STEP_ZERO_B: cur_byte = jse_pkg::CH_ZERO;
                    jse_pkg::STEP_HEX_HI: cur_byte = jse_pkg::HEX_DIGITS[head_desc.value[7:4]];
                    default:              cur_byte = jse_pkg::HEX_DIGITS[head_desc.value[3:0]];
                endcase
            end
            default: cur_byte = head_desc.value;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            step_next      = is_last ? '0 : step_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (load_en)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // a started sequence keeps its descriptor at the queue head
    assert property (@(posedge clk) disable iff (!rst_n) step_reg != '0 |-> head_valid)
        else $error("escape sequence lost its descriptor");
    // the step never runs past the length of the current sequence
    assert property (@(posedge clk) disable iff (!rst_n) head_valid |-> step_reg < len)
        else $error("step past end of sequence");
    // a descriptor leaves the queue only with the beat that ends its sequence
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> m_axis_tvalid && m_axis_tlast)
        else $error("pop without a last beat");

endmodule

@@ rtl/json_string_escaper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper_core: html-safe json string escaper
// turns open, byte and close items into the bytes of a quoted json string
// ----------------------------------------------------------------------------
//
// channel   dir  tdata                 tuser / tlast
// s_axis    in   [7:0] data_byte       tuser[1:0] mode (0 open, 1 byte, 2 close)
// m_axis    out  [7:0] out_byte        tlast = final byte of one input beat
//
// one output byte per cycle from the sequencer while m_axis is ready; an input
// beat that yields one byte (quote or plain byte) flows at one beat per cycle then
// a beat that yields n bytes (2 for short escapes, 6 for \u00xx) holds the
// sequencer until its last byte is loaded; the descriptor queue then fills and stalls s_axis
// a beat with mode 3 is taken and yields nothing
// reset clears queue pointers, step counter and output valid; no clear pass
// m_axis stalls hold the output register and back up through the queue only
//
module json_string_escaper_core
#(
    parameter int unsigned QueueDepth = jse_pkg::QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // output beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    // front to queue
    logic           push;
    jse_pkg::desc_t push_desc;
    logic           queue_full;

    // queue to back
    logic           pop;
    logic           head_valid;
    jse_pkg::desc_t head_desc;

    // classifier: decides quote, plain, short escape or unicode escape
    jse_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_desc     (push_desc)
    );

    // decouples classification from the multi-cycle byte output
    jse_queue
    #(
        .Depth (QueueDepth)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // sequencer with registered output
    jse_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_desc     (head_desc),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/sv/json_string_escaper_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper_core_tb: self-checking bench for the json string escaper
// drives open, byte and close beats with bursty gaps, stalls the output side
// on a changing pattern and checks every output byte and tlast against a
// predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------
module json_string_escaper_core_tb;

    // mode 3 carries no meaning; the block takes the beat and emits nothing
    localparam logic [1:0] MODE_NONE = 2'd3;

    // one expected output beat
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } out_beat_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the escaped bytes of each accepted input beat and
    // checks output beats against them in order
    // ------------------------------------------------------------------------
    class escape_scoreboard;
        out_beat_t   pending[$];
        int unsigned errors;
        int unsigned in_beats;
        int unsigned ignored_beats;
        int unsigned uni_escapes;
        int unsigned pair_escapes;
        int unsigned bytes_checked;

        function void add_beat(input logic [7:0] ch, input logic last);
            out_beat_t b;
            b.ch   = ch;
            b.last = last;
            pending.push_back(b);
        endfunction

        // expected bytes for one input beat, appended to the pending queue
        function void push_escaped(input logic [1:0] mode, input logic [7:0] src);
            if (mode == jse_pkg::MODE_OPEN || mode == jse_pkg::MODE_CLOSE) begin
                add_beat(jse_pkg::CH_QUOTE, 1'b1);
            end
            else if (mode == jse_pkg::MODE_BYTE) begin
                case (src)
                    jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH:
                    begin
                        add_beat(jse_pkg::CH_BSLASH, 1'b0);
                        add_beat(src, 1'b1);
                        pair_escapes++;
                    end
                    jse_pkg::CH_LF:
                    begin
                        add_beat(jse_pkg::CH_BSLASH, 1'b0);
                        add_beat(jse_pkg::CH_N, 1'b1);
                        pair_escapes++;
                    end
                    jse_pkg::CH_CR:
                    begin
                        add_beat(jse_pkg::CH_BSLASH, 1'b0);
                        add_beat(jse_pkg::CH_R, 1'b1);
                        pair_escapes++;
                    end
                    jse_pkg::CH_TAB:
                    begin
                        add_beat(jse_pkg::CH_BSLASH, 1'b0);
                        add_beat(jse_pkg::CH_T, 1'b1);
                        pair_escapes++;
                    end
                    default:
                    begin
                        if (src < jse_pkg::CTRL_LIMIT || src == jse_pkg::CH_LT
                            || src == jse_pkg::CH_GT || src == jse_pkg::CH_AMP)
                        begin
                            add_beat(jse_pkg::CH_BSLASH, 1'b0);
                            add_beat(jse_pkg::CH_U, 1'b0);
                            add_beat(jse_pkg::CH_ZERO, 1'b0);
                            add_beat(jse_pkg::CH_ZERO, 1'b0);
                            add_beat(jse_pkg::HEX_DIGITS[src[7:4]], 1'b0);
                            add_beat(jse_pkg::HEX_DIGITS[src[3:0]], 1'b1);
                            uni_escapes++;
                        end
                        else
                        begin
                            add_beat(src, 1'b1);
                        end
                    end
                endcase
            end
            else begin
                ignored_beats++;
            end
        endfunction

        function void note_input(input logic [1:0] mode, input logic [7:0] src);
            in_beats++;
            push_escaped(mode, src);
        endfunction

        function void check_output(input logic [7:0] ch, input logic last);
            out_beat_t exp_b;
            bytes_checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected output byte %h last %b", $time, ch, last);
                return;
            end
            exp_b = pending.pop_front();
            if (exp_b.ch !== ch || exp_b.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                             $time, exp_b.ch, exp_b.last, ch, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic [1:0] s_axis_tuser;   // [1:0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;

    escape_scoreboard sb = new();

    // sender burst bookkeeping
    int unsigned burst_left = 0;

    // receiver stall pattern bookkeeping
    int unsigned stall_style = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_tick  = 0;

    json_string_escaper_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: tready follows a style that is picked anew when its random run ends
    // styles: always ready, coin flip, periodic one-in-four stall, mostly stalled
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(10, 60);
        end
        stall_left--;
        stall_tick++;
        case (stall_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (stall_tick % 4) != 3;
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // monitor: all signals change only at rising edges, so values seen at the
    // falling edge are the ones that the next rising edge will take
    // inputs are noted before outputs are checked in the same cycle
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // sender: one beat, held until the block takes it; bursts of random
    // length separated by random gaps, some bursts run back to back
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] src);
        int unsigned gap;
        bit          taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= src;
        s_axis_tuser  <= mode;
        do begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end while (!taken);
    endtask

    // source byte biased toward the characters that get escaped
    function automatic logic [7:0] pick_byte();
        logic [7:0] specials [12] = '{
            jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, jse_pkg::CH_LF, jse_pkg::CH_CR,
            jse_pkg::CH_TAB, jse_pkg::CH_LT, jse_pkg::CH_GT, jse_pkg::CH_AMP,
            8'h00, 8'h1F, jse_pkg::CTRL_LIMIT, 8'hFF
        };
        if ($urandom_range(0, 9) < 3)
            return specials[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned counted;
        int unsigned len;
        int unsigned drain;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= jse_pkg::MODE_OPEN;
        m_axis_tready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one string holding every escape class and the byte extremes
        send_beat(jse_pkg::MODE_OPEN, 8'hA5);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_QUOTE);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_BSLASH);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_LF);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_CR);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_TAB);
        send_beat(jse_pkg::MODE_BYTE, 8'h00);              // zero byte is a control byte, sent as a unicode escape
        send_beat(jse_pkg::MODE_BYTE, 8'h1F);              // highest control byte
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CTRL_LIMIT); // space passes through
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_LT);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_GT);
        send_beat(jse_pkg::MODE_BYTE, jse_pkg::CH_AMP);
        send_beat(jse_pkg::MODE_BYTE, 8'h41);
        send_beat(jse_pkg::MODE_BYTE, 8'h7F);
        send_beat(jse_pkg::MODE_BYTE, 8'h80);              // high bytes pass, no utf-8 check
        send_beat(jse_pkg::MODE_BYTE, 8'hFF);
        send_beat(MODE_NONE, 8'hFF);                       // ignored beat inside a string
        send_beat(jse_pkg::MODE_CLOSE, 8'h5A);
        // order of open and close is never checked
        send_beat(jse_pkg::MODE_CLOSE, 8'h00);
        send_beat(jse_pkg::MODE_CLOSE, 8'hFF);
        send_beat(jse_pkg::MODE_OPEN, 8'h00);
        send_beat(jse_pkg::MODE_OPEN, 8'h22);
        send_beat(MODE_NONE, 8'h00);

        // random: mostly well-formed strings with random content, some noise
        counted = 0;
        while (counted < 75) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(0, 10);
                send_beat(jse_pkg::MODE_OPEN, 8'($urandom_range(0, 255)));
                repeat (len) send_beat(jse_pkg::MODE_BYTE, pick_byte());
                send_beat(jse_pkg::MODE_CLOSE, 8'($urandom_range(0, 255)));
                counted += len + 2;
            end
            else begin
                // stray open, close or ignored beat, or an unopened byte
                case ($urandom_range(0, 3))
                    0: send_beat(jse_pkg::MODE_OPEN, 8'($urandom_range(0, 255)));
                    1: send_beat(jse_pkg::MODE_CLOSE, 8'($urandom_range(0, 255)));
                    2: send_beat(jse_pkg::MODE_BYTE, pick_byte());
                    default: send_beat(MODE_NONE, 8'($urandom_range(0, 255)));
                endcase
                counted++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain everything expected, then give the block room to misbehave
        while (sb.pending.size() != 0) @(posedge clk);
        drain = 0;
        while (drain < 40) begin
            @(posedge clk);
            drain++;
        end

        if (sb.pending.size() != 0) begin
            sb.errors++;
            $display("%0d expected output bytes never arrived", sb.pending.size());
        end

        $display("covered %0d input beats (%0d with mode 3), %0d output bytes checked",
                 sb.in_beats, sb.ignored_beats, sb.bytes_checked);
        $display("escapes seen: %0d two-byte, %0d six-byte; %0d errors",
                 sb.pair_escapes, sb.uni_escapes, sb.errors);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
